@@ rtl/core/positional_list_engine_top_macros.svh @@
// Assertion macros for the positional list engine.
// Included by the RTL files that carry concurrent checks.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, reset gated.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset gated.
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
// Package for the positional list engine: beat types, codes, control structs.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 8;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT      = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_LAST   = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] element;
        logic [POS_W-1:0]  position;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [DATA_W-1:0]  read_value;
        logic               read_valid;
        logic [DATA_W-1:0]  released_value;
        logic               released_valid;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ple_cmd_t;

endpackage

@@ rtl/core/ple_ctrl.sv @@
// Controller FSM for the positional list engine: accepts a start beat, then drives
// the execute command to the datapath. Depends on ple_pkg.
`timescale 1ns / 1ps
`include "positional_list_engine_top_macros.svh"

module ple_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output ple_pkg::ple_cmd_t cmd
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `PLE_ASSERT_NXT(a_exec_one_cycle, clk, rst_n, busy, !busy, "execute phase longer than one cycle")
    `PLE_ASSERT_NXT(a_accept_to_exec, clk, rst_n, start && !busy, cmd.exec, "accepted beat not executed")

endmodule

@@ rtl/core/ple_datapath.sv @@
// Datapath for the positional list engine: entry register array with parallel shift,
// count, release enable and result register. Depends on ple_pkg.
`timescale 1ns / 1ps
`include "positional_list_engine_top_macros.svh"

module ple_datapath #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ple_pkg::ple_cmd_t cmd,
    input  ple_pkg::item_t    item,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    output ple_pkg::result_t  result,
    output logic              done
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    item_t                    item_reg;
    logic [ELEMENT_WIDTH-1:0] entries_reg [DEPTH];
    logic [ELEMENT_WIDTH-1:0] entry_next  [DEPTH];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     release_enable_reg;
    result_t                  result_reg, result_next;
    logic                     done_reg;

    logic [CMP_W-1:0]         cnt_ext, pos_ext, last_ext;
    logic [CMP_W-1:0]         ins_pos, rem_pos, rd_sel;
    logic                     is_insert, is_remove, is_read;
    logic                     empty, full, do_insert, do_remove;
    logic [ELEMENT_WIDTH-1:0] rd_data, new_elem;

    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(item_reg.position);
    assign last_ext  = cnt_ext - CMP_W'(1);
    assign empty     = (count_reg == '0);
    assign full      = (cnt_ext >= CMP_W'(DEPTH));
    assign new_elem  = ELEMENT_WIDTH'(item_reg.element);

    assign is_insert = (item_reg.operation == OP_APPEND) || (item_reg.operation == OP_INSERT);
    assign is_remove = (item_reg.operation == OP_REMOVE_LAST)
                    || (item_reg.operation == OP_REMOVE_AT);
    assign is_read   = (item_reg.operation == OP_READ_AT) || (item_reg.operation == OP_READ_LAST);

    assign do_insert = is_insert && !full;
    assign do_remove = is_remove && !empty;

    assign ins_pos = ((item_reg.operation == OP_APPEND) || (pos_ext >= cnt_ext))
                   ? cnt_ext : pos_ext;
    assign rem_pos = ((item_reg.operation == OP_REMOVE_LAST) || (pos_ext >= cnt_ext))
                   ? last_ext : pos_ext;

    // single read port shared by removal and read
    always_comb
    begin
        if (is_remove)
            rd_sel = rem_pos;
        else if (item_reg.operation == OP_READ_LAST)
            rd_sel = last_ext;
        else
            rd_sel = pos_ext;
    end

    assign rd_data = entries_reg[rd_sel[IDX_W-1:0]];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        logic [ELEMENT_WIDTH-1:0] prev_val, succ_val;

        if (g == 0)
        begin : g_first
            assign prev_val = entries_reg[g];
        end
        else
        begin : g_prev
            assign prev_val = entries_reg[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign succ_val = entries_reg[g];
        end
        else
        begin : g_succ
            assign succ_val = entries_reg[g+1];
        end

        always_comb
        begin
            entry_next[g] = entries_reg[g];
            if (do_insert)
            begin
                if (CMP_W'(g) == ins_pos)
                    entry_next[g] = new_elem;
                else if (CMP_W'(g) > ins_pos)
                    entry_next[g] = prev_val;
            end
            else if (do_remove)
            begin
                if (CMP_W'(g) >= rem_pos)
                    entry_next[g] = succ_val;
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        if (is_insert)
        begin
            if (full)
                result_next.status = ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (is_remove)
        begin
            if (empty)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                if (release_enable_reg)
                begin
                    result_next.released_value = DATA_W'(rd_data);
                    result_next.released_valid = 1'b1;
                end
            end
        end
        else if (is_read)
        begin
            if (empty)
            begin
                result_next.status = ST_EMPTY;
            end
            else if (rd_sel < cnt_ext)
            begin
                result_next.read_value = DATA_W'(rd_data);
                result_next.read_valid = 1'b1;
            end
        end
        result_next.entry_count = COUNT_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (cmd.exec)
        begin
            entries_reg <= entry_next;
            result_reg  <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg          <= '0;
            release_enable_reg <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
                count_reg <= count_next;
            if (cfg_wr_en)
                release_enable_reg <= cfg_wr_data;
            done_reg <= cmd.exec;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    `PLE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_ext <= CMP_W'(DEPTH), "count above depth")
    `PLE_ASSERT_NOW(a_done_follows_exec, clk, rst_n, done, $past(cmd.exec), "result without execute")
    `PLE_ASSERT_NXT(a_full_no_growth, clk, rst_n, cmd.exec && is_insert && full,
        count_reg == $past(count_reg), "insert into full list changed count")

endmodule

@@ rtl/core/positional_list_engine_top.sv @@
// Top level of the positional list engine: bounded ordered list of element handles.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
`timescale 1ns / 1ps
//
// Usage:
//   Command channel: drive item and raise start; the beat is taken at a rising edge
//   with start high and busy low. busy is high for the one execute cycle after it.
//   Operations: append, insert at position, remove last, remove at position,
//   read at position, read last. Codes six and seven do nothing.
//   Result channel: done pulses for one cycle with the result beat on result.
//   The receiver has no back pressure; it must take the beat in that cycle.
//   Result and done are registered: the accepted beat is held in item_reg,
//   then the execute state writes result_reg and done_reg. The controller's
//   load/execute sequence takes no new item while busy. Each operation ends in the
//   execute state; all entries behind the position shift in parallel.
//   Configuration: cfg_wr_en/cfg_wr_data write release_enable at the clock edge;
//   write only while no item is in flight.
//   Reset: rst_n clears the count (empty list) and release_enable; the entry
//   store holds no reset value and is never read before being written.
//
module positional_list_engine_top #(
    parameter int DEPTH         = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ple_pkg::item_t   item,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    output ple_pkg::result_t result,
    output logic             done
);
    import ple_pkg::*;

    ple_cmd_t cmd;

    ple_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    ple_datapath #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result),
        .done        (done)
    );

endmodule
